// File: rtl/core/isct_pkg.sv
// Package for the image sensor control translator: types, codes, register
// addresses and the gain tables. No dependencies.
package isct_pkg;

	localparam int GAIN_STEPS_DEF = 41;
	localparam int TABLE_ROWS = 41;
	localparam int QDEPTH = 2;

	localparam logic [1:0] ACT_GAIN = 2'd0;
	localparam logic [1:0] ACT_EXPO = 2'd1;
	localparam logic [1:0] ACT_PATT = 2'd2;
	localparam logic [1:0] ACT_REPLAY = 2'd3;

	localparam logic [1:0] CFG_PCLK = 2'd0;
	localparam logic [1:0] CFG_WIDTH = 2'd1;
	localparam logic [1:0] CFG_MAXROWS = 2'd2;
	localparam logic [1:0] CFG_POWER = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_PATTERN = 2'd1;
	localparam logic [1:0] ST_BAD_TIMING = 2'd2;

	localparam logic [15:0] A_GAIN_AH = 16'h124a;
	localparam logic [15:0] A_GAIN_AL = 16'h1249;
	localparam logic [15:0] A_GAIN_DH = 16'h124d;
	localparam logic [15:0] A_GAIN_DL = 16'h124c;
	localparam logic [15:0] A_EXPO = 16'h1243;
	localparam logic [15:0] A_TP = 16'h111B;
	localparam logic [15:0] A_CB1 = 16'h1121;
	localparam logic [15:0] A_CB2 = 16'h1124;
	localparam logic [15:0] A_DIN = 16'h112C;
	localparam logic [15:0] A_1420 = 16'h1420;
	localparam logic [17:0] US_QUARTER = 18'(1000000 >> 2);

	// Classified request handed from the front to the back.
	typedef struct packed {
		logic [1:0]  action;
		logic        neg;      // value below zero
		logic [31:0] value;
		logic        pat_ok;   // value in 0..8
	} req_t;

	typedef enum logic [4:0] {
		S_IDLE, S_START, S_GAIN, S_EXPO_DIV1, S_EXPO_DIV2, S_EXPO_MUL,
		S_EXPO_CLAMP, S_EXPO_DIV3, S_EXPO_ST, S_EXPO_EMIT, S_PATT,
		S_STATUS, S_DONE
	} bstate_t;

	typedef enum logic [1:0] {D_IDLE, D_RUN} dstate_t;

	function automatic logic [8:0] gain_analog(input logic [5:0] r);
		logic [8:0] t;
		t = 9'd256;
		unique case (r)
			6'd0: t = 9'd32;   6'd1: t = 9'd34;   6'd2: t = 9'd37;
			6'd3: t = 9'd39;   6'd4: t = 9'd42;   6'd5: t = 9'd45;
			6'd6: t = 9'd49;   6'd7: t = 9'd52;   6'd8: t = 9'd56;
			6'd9: t = 9'd60;   6'd10: t = 9'd64;  6'd11: t = 9'd69;
			6'd12: t = 9'd74;  6'd13: t = 9'd79;  6'd14: t = 9'd84;
			6'd15: t = 9'd91;  6'd16: t = 9'd97;  6'd17: t = 9'd104;
			6'd18: t = 9'd111; 6'd19: t = 9'd119; 6'd20: t = 9'd128;
			6'd21: t = 9'd137; 6'd22: t = 9'd147; 6'd23: t = 9'd158;
			6'd24: t = 9'd169; 6'd25: t = 9'd181; 6'd26: t = 9'd194;
			6'd27: t = 9'd208; 6'd28: t = 9'd223; 6'd29: t = 9'd239;
			default: t = 9'd256;
		endcase
		return t;
	endfunction

	function automatic logic [9:0] gain_digital(input logic [5:0] r);
		logic [9:0] t;
		t = 10'd0;
		unique case (r)
			6'd31: t = 10'd73;  6'd32: t = 10'd152; 6'd33: t = 10'd236;
			6'd34: t = 10'd327; 6'd35: t = 10'd424; 6'd36: t = 10'd528;
			6'd37: t = 10'd639; 6'd38: t = 10'd758; 6'd39: t = 10'd886;
			6'd40: t = 10'd1023;
			default: t = 10'd0;
		endcase
		return t;
	endfunction

endpackage

// File: rtl/core/image_sensor_control_translator_top.sv
// Image sensor control translator, top level.
// Exposure and replay items run three divisions in the shared serial divider.
// Throughput: one item at a time in the back end; a two-word queue lets the front
// accept while the back works. Reset clears the configuration and the stored
// gain, exposure and pattern to zero; the data path registers are not reset.
module image_sensor_control_translator_top #(
	parameter int GAIN_STEPS = isct_pkg::GAIN_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        reg_addr,
	output logic [15:0]        reg_data,
	output logic               reg_wide,
	output logic               write_valid,
	output logic [31:0]        applied_value,
	output logic [1:0]         status,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	// Configuration registers; writes are taken at any time.
	logic [28:0] pclk_q;
	logic [13:0] lw_q;
	logic [15:0] maxrows_q;
	logic        power_q;
	logic        q_valid, q_pop;
	isct_pkg::req_t q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pclk_q <= 29'd0;
			lw_q <= 14'd0;
			maxrows_q <= 16'd0;
			power_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				isct_pkg::CFG_PCLK: pclk_q <= cfg_data[28:0];
				isct_pkg::CFG_WIDTH: lw_q <= cfg_data[13:0];
				isct_pkg::CFG_MAXROWS: maxrows_q <= cfg_data[15:0];
				default: power_q <= cfg_data[0];
			endcase
		end
	end

	// The front classifies requests and queues them.
	isct_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.action(action), .value(value), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head)
	);

	// The back sequences each request into its register writes.
	isct_back #(.GAIN_STEPS(GAIN_STEPS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop),
		.q_head(q_head), .pclk(pclk_q), .lw(lw_q), .maxrows(maxrows_q),
		.powered(power_q), .out_valid(out_valid), .out_ready(out_ready),
		.reg_addr(reg_addr), .reg_data(reg_data), .reg_wide(reg_wide),
		.write_valid(write_valid), .applied_value(applied_value),
		.status(status), .last(last)
	);
endmodule

// File: rtl/core/isct_div.sv
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
// Uses no package items.
module isct_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [47:0] quotient
);
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q[31:0], quo_q[47]};
	assign diff = trial - {1'b0, dvs_q};
	assign busy = (cnt_q != 6'd0);
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= 33'd0;
			dvs_q <= divisor;
		end else if (busy) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end
endmodule

// File: rtl/core/isct_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on isct_pkg.
module isct_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	output logic               q_valid,
	input  logic               q_pop,
	output isct_pkg::req_t     q_head
);
	localparam int QD = isct_pkg::QDEPTH;
	isct_pkg::req_t ent_q [QD];
	logic [1:0] cnt_q;
	logic       wp_q, rp_q;
	isct_pkg::req_t cls;
	logic push;

	always_comb begin
		cls.action = action;
		cls.neg = value[31];
		cls.value = value;
		cls.pat_ok = !value[31] && (value < 32'sd9);
	end

	assign in_ready = (cnt_q != 2'(QD));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= cls;
	end
endmodule

// File: rtl/core/isct_back.sv
// Back end: sequences gain, exposure and pattern updates into register writes.
// Depends on isct_pkg and isct_div.
module isct_back #(
	parameter int GAIN_STEPS = isct_pkg::GAIN_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  isct_pkg::req_t q_head,
	input  logic [28:0]    pclk,
	input  logic [13:0]    lw,
	input  logic [15:0]    maxrows,
	input  logic           powered,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [15:0]    reg_addr,
	output logic [15:0]    reg_data,
	output logic           reg_wide,
	output logic           write_valid,
	output logic [31:0]    applied_value,
	output logic [1:0]     status,
	output logic           last
);
	localparam logic [5:0] GMAX = 6'(GAIN_STEPS - 1);

	isct_pkg::bstate_t st_q, st_d;
	isct_pkg::req_t    req_q;
	logic [5:0]  gain_q;
	logic [31:0] expo_q;
	logic [3:0]  patt_q;
	logic [2:0]  sub_q;
	logic [32:0] ereq_q;   // signed request, 33 bits
	logic [31:0] rowus_q, rt_q;
	logic [47:0] e_q;
	logic [15:0] rows_q;
	logic [48:0] stw_q;
	logic        ovalid_q;
	logic [15:0] oaddr_q, odata_q;
	logic        owide_q, owv_q, olast_q;
	logic [31:0] oapp_q;
	logic [1:0]  ostat_q;

	logic [27:0] c4, c10;
	logic [31:0] num;
	logic        tbad;
	logic        dstart;
	logic [47:0] dend;
	logic [31:0] dsor;
	logic        dbusy;
	logic [47:0] dquo;
	logic [48:0] dsum;
	logic        oslot;
	logic        emit;
	logic [15:0] eaddr, edata;
	logic        ewide, ewv, elast;
	logic [31:0] eapp;
	logic [1:0]  estat;
	logic [5:0]  grow;
	logic [8:0]  ga;
	logic [9:0]  gd;
	logic [3:0]  tp;
	logic        cb, din;
	logic [5:0]  gnew;
	logic [31:0] eclip;

	assign c4 = 28'((30'(pclk) + 30'd2) >> 2);
	assign c10 = 28'((30'(pclk) + 30'd512) >> 10);
	assign num = 32'(lw) * 32'(isct_pkg::US_QUARTER);
	assign tbad = (pclk == 29'd0) || (lw == 14'd0) || (c10 == 28'd0);
	assign grow = (gain_q < 6'(isct_pkg::TABLE_ROWS)) ? gain_q : 6'(isct_pkg::TABLE_ROWS - 1);
	assign ga = isct_pkg::gain_analog(grow);
	assign gd = isct_pkg::gain_digital(grow);
	assign oslot = !ovalid_q || out_ready;
	// Scaled exposure plus half a row time; a carry or a huge exposure always
	// saturates the row count, so the dividend is pinned to all ones then.
	assign dsum = {1'b0, e_q[39:0], 8'd0} + 49'(rt_q[31:1]);

	isct_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(dend),
		.divisor(dsor), .busy(dbusy), .quotient(dquo)
	);

	always_comb begin
		if (req_q.neg) gnew = 6'd0;
		else if (req_q.value > 32'(GMAX)) gnew = GMAX;
		else gnew = req_q.value[5:0];
		eclip = (stw_q[48:40] != 9'd0) ? 32'hFFFF_FFFF : stw_q[39:8];
		tp = 4'd0; cb = 1'b0; din = 1'b0;
		if (patt_q != 4'd0) begin
			din = 1'b1;
			if (patt_q < 4'd5) begin
				cb = 1'b1; tp = patt_q + 4'd3;
			end else begin
				tp = patt_q - 4'd1;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		q_pop = 1'b0;
		dstart = 1'b0;
		dend = 48'd0;
		dsor = 32'd1;
		emit = 1'b0;
		eaddr = 16'd0; edata = 16'd0; ewide = 1'b0; ewv = 1'b0;
		eapp = 32'd0; estat = isct_pkg::ST_OK; elast = 1'b0;
		unique case (st_q)
			isct_pkg::S_IDLE: if (q_valid) st_d = isct_pkg::S_START;
			isct_pkg::S_START: begin
				q_pop = 1'b1;
				unique case (req_q.action)
					isct_pkg::ACT_GAIN: st_d = isct_pkg::S_GAIN;
					isct_pkg::ACT_EXPO: st_d = isct_pkg::S_EXPO_DIV1;
					isct_pkg::ACT_PATT: st_d = req_q.pat_ok ? isct_pkg::S_PATT
						: isct_pkg::S_STATUS;
					default: st_d = ((pclk == 29'd0) || (lw == 14'd0))
						? isct_pkg::S_STATUS : isct_pkg::S_GAIN;
				endcase
			end
			isct_pkg::S_GAIN: begin
				eapp = 32'(gain_q);
				ewv = 1'b1;
				unique case (sub_q[1:0])
					2'd0: begin eaddr = isct_pkg::A_GAIN_AH; edata = 16'(ga[8]); end
					2'd1: begin eaddr = isct_pkg::A_GAIN_AL; edata = 16'(ga[7:0]); end
					2'd2: begin eaddr = isct_pkg::A_GAIN_DH; edata = 16'(gd[9:8]); end
					default: begin eaddr = isct_pkg::A_GAIN_DL; edata = 16'(gd[7:0]); end
				endcase
				if (!powered) begin
					st_d = (req_q.action == isct_pkg::ACT_GAIN) ? isct_pkg::S_STATUS
						: isct_pkg::S_EXPO_DIV1;
				end else if (oslot) begin
					emit = 1'b1;
					if (sub_q[1:0] == 2'd3) begin
						elast = (req_q.action == isct_pkg::ACT_GAIN);
						st_d = elast ? isct_pkg::S_DONE : isct_pkg::S_EXPO_DIV1;
					end
				end
			end
			isct_pkg::S_EXPO_DIV1: begin
				if (tbad) st_d = isct_pkg::S_STATUS;
				else if (!dbusy) begin
					dstart = 1'b1;
					dend = 48'(num) + 48'(c4 >> 1);
					dsor = 32'(c4);
					st_d = isct_pkg::S_EXPO_DIV2;
				end
			end
			isct_pkg::S_EXPO_DIV2: if (!dbusy && sub_q == 3'd1) begin
				dstart = 1'b1;
				dend = 48'(num) + 48'(c10 >> 1);
				dsor = 32'(c10);
				st_d = isct_pkg::S_EXPO_MUL;
			end
			isct_pkg::S_EXPO_MUL: if (!dbusy && sub_q == 3'd1) begin
				st_d = (dquo == 48'd0) ? isct_pkg::S_STATUS : isct_pkg::S_EXPO_CLAMP;
			end
			isct_pkg::S_EXPO_CLAMP: if (sub_q == 3'd1) st_d = isct_pkg::S_EXPO_DIV3;
			isct_pkg::S_EXPO_DIV3: if (!dbusy) begin
				if (sub_q == 3'd0) begin
					dstart = 1'b1;
					dend = (e_q[47:40] != 8'd0 || dsum[48]) ? 48'hFFFF_FFFF_FFFF
						: dsum[47:0];
					dsor = rt_q;
				end else begin
					st_d = isct_pkg::S_EXPO_ST;
				end
			end
			isct_pkg::S_EXPO_ST: st_d = isct_pkg::S_EXPO_EMIT;
			isct_pkg::S_EXPO_EMIT: begin
				eapp = eclip;
				if (!powered) begin
					st_d = (req_q.action == isct_pkg::ACT_EXPO) ? isct_pkg::S_STATUS
						: isct_pkg::S_PATT;
				end else if (oslot) begin
					emit = 1'b1;
					ewv = 1'b1; ewide = 1'b1;
					eaddr = isct_pkg::A_EXPO;
					edata = {rows_q[7:0], rows_q[15:8]};
					elast = (req_q.action == isct_pkg::ACT_EXPO);
					st_d = elast ? isct_pkg::S_DONE : isct_pkg::S_PATT;
				end
			end
			isct_pkg::S_PATT: begin
				eapp = 32'(patt_q);
				ewv = 1'b1;
				unique case (sub_q)
					3'd0: begin eaddr = isct_pkg::A_TP; edata = 16'({tp, 4'd0}); end
					3'd1: begin eaddr = isct_pkg::A_CB1; edata = 16'({cb, 7'd0}); end
					3'd2: begin eaddr = isct_pkg::A_CB2; edata = 16'({cb, 7'd0}); end
					3'd3: begin eaddr = isct_pkg::A_DIN; edata = 16'(din); end
					default: begin
						eaddr = isct_pkg::A_1420;
						edata = din ? 16'h00E0 : 16'h00F0;
					end
				endcase
				if (!powered) st_d = isct_pkg::S_STATUS;
				else if (oslot) begin
					emit = 1'b1;
					if (sub_q == 3'd4) begin
						elast = 1'b1;
						st_d = isct_pkg::S_DONE;
					end
				end
			end
			isct_pkg::S_STATUS: begin
				if (oslot) begin
					emit = 1'b1; elast = 1'b1;
					st_d = isct_pkg::S_DONE;
					unique case (req_q.action)
						isct_pkg::ACT_GAIN: eapp = 32'(gain_q);
						isct_pkg::ACT_PATT: begin
							eapp = 32'(patt_q);
							if (!req_q.pat_ok) estat = isct_pkg::ST_BAD_PATTERN;
						end
						default: begin
							eapp = expo_q;
							if (sub_q[0]) estat = isct_pkg::ST_BAD_TIMING;
						end
					endcase
				end
			end
			default: st_d = isct_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= isct_pkg::S_IDLE;
			sub_q <= 3'd0;
			ovalid_q <= 1'b0;
			gain_q <= 6'd0;
			expo_q <= 32'd0;
			patt_q <= 4'd0;
		end else begin
			if (emit) ovalid_q <= 1'b1;
			else if (out_valid && out_ready) ovalid_q <= 1'b0;
			st_q <= st_d;
			// sub_q counts writes in a step and is 1 while a division runs; in
			// S_STATUS bit 0 flags bad timing.
			if (st_d != st_q) begin
				if (dstart || (st_d == isct_pkg::S_STATUS && (st_q == isct_pkg::S_EXPO_DIV1
					|| st_q == isct_pkg::S_EXPO_MUL || (st_q == isct_pkg::S_START
					&& req_q.action == isct_pkg::ACT_REPLAY))))
					sub_q <= 3'd1;
				else
					sub_q <= 3'd0;
			end else if (emit || dstart) begin
				sub_q <= sub_q + 3'd1;
			end else if (st_q == isct_pkg::S_EXPO_CLAMP) begin
				sub_q <= 3'd1;
			end
			if (st_q == isct_pkg::S_START) begin
				if (req_q.action == isct_pkg::ACT_GAIN) gain_q <= gnew;
				if (req_q.action == isct_pkg::ACT_PATT && req_q.pat_ok)
					patt_q <= req_q.value[3:0];
				if (req_q.action == isct_pkg::ACT_REPLAY && patt_q > 4'd8)
					patt_q <= 4'd0;
			end
			if (st_q == isct_pkg::S_EXPO_EMIT) expo_q <= eclip;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == isct_pkg::S_IDLE && q_valid) req_q <= q_head;
		if (st_q == isct_pkg::S_START)
			ereq_q <= (req_q.action == isct_pkg::ACT_REPLAY) ? {1'b0, expo_q}
				: {req_q.value[31], req_q.value};
		if (st_q == isct_pkg::S_EXPO_DIV2 && sub_q == 3'd1 && !dbusy)
			rowus_q <= dquo[31:0];
		if (st_q == isct_pkg::S_EXPO_MUL && !dbusy && sub_q == 3'd1) begin
			rt_q <= dquo[31:0];
			e_q <= 48'(maxrows) * 48'(rowus_q);  // upper bound
		end
		if (st_q == isct_pkg::S_EXPO_CLAMP && sub_q == 3'd0) begin
			// A replay with zero stored exposure asks for the maximum, which
			// e_q already holds.
			if (!(req_q.action == isct_pkg::ACT_REPLAY && ereq_q == 33'd0)) begin
				if (ereq_q[32] || 48'(ereq_q[31:0]) < 48'(rowus_q)) begin
					if (48'(rowus_q) < e_q) e_q <= 48'(rowus_q);
				end else if (48'(ereq_q[31:0]) < e_q) begin
					e_q <= 48'(ereq_q[31:0]);
				end
			end
		end
		if (st_q == isct_pkg::S_EXPO_DIV3 && !dbusy && sub_q == 3'd1)
			rows_q <= (dquo[47:16] != 32'd0) ? 16'hFFFF : dquo[15:0];
		if (st_q == isct_pkg::S_EXPO_ST)
			stw_q <= 49'(48'(rt_q) * 48'(rows_q)) + 49'd128;
		if (emit) begin
			oaddr_q <= eaddr; odata_q <= edata; owide_q <= ewide; owv_q <= ewv;
			oapp_q <= eapp; ostat_q <= estat; olast_q <= elast;
		end
	end

	// The stored exposure is rounded from stw_q, which is ready from the
	// emit state on.
	assign out_valid = ovalid_q;
	assign reg_addr = oaddr_q;
	assign reg_data = odata_q;
	assign reg_wide = owide_q;
	assign write_valid = owv_q;
	assign applied_value = oapp_q;
	assign status = ostat_q;
	assign last = olast_q;
endmodule
